/* design/pttre_pkg.sv */
// package for the photon time-tag record encoder
// word types of both channels, status codes, record type codes, default field sizes
// no dependencies
`default_nettype none

package pttre_pkg;

  // default bit counts of the packed time fields
  localparam int unsigned MacroBitsDef = 28;
  localparam int unsigned MicroBitsDef = 34;

  // bytes that one emitted record adds to the byte total
  localparam logic [63:0] BytesPerRecord = 64'd8;

  // record type in bits 1:0 of a record word
  localparam logic [1:0] RecPhoton   = 2'd0;
  localparam logic [1:0] RecOverflow = 2'd1;

  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StBackwards  = 2'd1,
    StMicroRange = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [63:0] macro_time;
    logic signed [63:0] micro_time;
  } event_t;

  typedef struct packed {
    logic [63:0] record_word;
    logic        record_valid;
    logic        last_of_item;
    status_e     status;
    logic [63:0] photons_total;
    logic [35:0] overflows_total;
    logic [63:0] bytes_total;
  } record_t;

endpackage

`default_nettype wire

/* design/pttre_if.sv */
// valid/ready stream channel for the photon time-tag record encoder
// depends on pttre_pkg for the default word type
`default_nettype none

interface pttre_if #(
  parameter type word_t = pttre_pkg::event_t
);

  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

/* design/photon_time_tag_record_encoder.sv */
// photon time-tag record encoder: top level
// output: the first result word is offered in the cycle after the event word is taken
// throughput: one event per cycle while each event yields one result word and the output is ready;
//   an event that needs an overflow record yields two words and holds the input until that record is taken
// reset: rst_ni clears the last macrotime, all running totals and the result pending flags
// depends on pttre_pkg and pttre_if
`default_nettype none

module photon_time_tag_record_encoder #(
  parameter int unsigned MACRO_BITS = pttre_pkg::MacroBitsDef,
  parameter int unsigned MICRO_BITS = pttre_pkg::MicroBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pttre_if.sink     event_i,
  pttre_if.source   record_o
);

  // masks for the packed time fields
  localparam logic [63:0] MacroMask = (64'd1 << MACRO_BITS) - 64'd1;
  localparam logic [63:0] MicroMask = (64'd1 << MICRO_BITS) - 64'd1;
  localparam int unsigned MicroPos  = MICRO_BITS + 2;

  // running state
  logic [63:0] last_macro_q, last_macro_d;
  logic [35:0] ovf_cnt_q, ovf_cnt_d;
  logic [63:0] photon_cnt_q, photon_cnt_d;
  logic [63:0] byte_cnt_q, byte_cnt_d;

  // result slots: the overflow record goes out ahead of the final word of an event
  logic                pend_ovf_q, pend_ovf_d;
  logic                pend_fin_q, pend_fin_d;
  pttre_pkg::record_t  ovf_slot_q, ovf_slot_d;
  pttre_pkg::record_t  fin_slot_q, fin_slot_d;

  logic        in_take;
  logic        out_take;
  logic [63:0] macro_u;
  logic [63:0] micro_u;
  logic        backwards;
  logic        micro_big;
  logic [63:0] rest;
  logic [63:0] periods;
  logic        ovf_hit;
  logic [63:0] photon_word;

  // byte growth for one or two records
  function automatic logic [63:0] BytesPerRecordSum(input logic [1:0] n_rec);
    BytesPerRecordSum = pttre_pkg::BytesPerRecord * 64'(n_rec);
  endfunction

  // the input waits only while the overflow slot is full, or the final slot stays full
  assign event_i.ready  = !pend_ovf_q && (!pend_fin_q || record_o.ready);
  assign in_take        = event_i.valid && event_i.ready;

  assign record_o.valid = pend_ovf_q || pend_fin_q;
  assign record_o.data  = pend_ovf_q ? ovf_slot_q : fin_slot_q;
  assign out_take       = record_o.valid && record_o.ready;

  always_comb begin
    macro_u   = 64'(event_i.data.macro_time);
    micro_u   = 64'(event_i.data.micro_time);

    // macrotime must not go backwards (signed compare); backwards wins over range
    backwards = $signed(macro_u) < $signed(last_macro_q);
    // negative microtimes pass and are masked below
    micro_big = !micro_u[63] && ((micro_u >> MICRO_BITS) != 64'd0);

    // strip the periods already reported
    rest      = macro_u - (64'(ovf_cnt_q) << MACRO_BITS);
    periods   = rest >> MACRO_BITS;
    ovf_hit   = !rest[63] && (periods != 64'd0);

    // low bits of rest equal those of the macrotime, the subtrahend has none there
    photon_word = ((micro_u & MicroMask) << 2)
                | ((rest & MacroMask) << MicroPos)
                | 64'(pttre_pkg::RecPhoton);
  end

  always_comb begin
    last_macro_d = last_macro_q;
    ovf_cnt_d    = ovf_cnt_q;
    photon_cnt_d = photon_cnt_q;
    byte_cnt_d   = byte_cnt_q;
    pend_ovf_d   = pend_ovf_q;
    pend_fin_d   = pend_fin_q;
    ovf_slot_d   = ovf_slot_q;
    fin_slot_d   = fin_slot_q;

    // retire the word being taken; the overflow record always leaves first
    if (out_take) begin
      if (pend_ovf_q) begin
        pend_ovf_d = 1'b0;
      end else begin
        pend_fin_d = 1'b0;
      end
    end

    if (in_take) begin
      pend_fin_d = 1'b1;
      if (backwards || micro_big) begin
        // rejected event: one empty word, totals untouched
        fin_slot_d.record_word     = 64'd0;
        fin_slot_d.record_valid    = 1'b0;
        fin_slot_d.last_of_item    = 1'b1;
        fin_slot_d.status          = backwards ? pttre_pkg::StBackwards
                                               : pttre_pkg::StMicroRange;
        fin_slot_d.photons_total   = photon_cnt_q;
        fin_slot_d.overflows_total = ovf_cnt_q;
        fin_slot_d.bytes_total     = byte_cnt_q;
      end else begin
        last_macro_d = macro_u;
        if (ovf_hit) begin
          ovf_cnt_d  = ovf_cnt_q + periods[35:0];
          byte_cnt_d = byte_cnt_q + BytesPerRecordSum(2'd2);
          pend_ovf_d = 1'b1;
          // period count fits in 62 bits since rest is non-negative
          ovf_slot_d.record_word     = {periods[61:0], pttre_pkg::RecOverflow};
          ovf_slot_d.record_valid    = 1'b1;
          ovf_slot_d.last_of_item    = 1'b0;
          ovf_slot_d.status          = pttre_pkg::StOk;
          ovf_slot_d.photons_total   = photon_cnt_q;
          ovf_slot_d.overflows_total = ovf_cnt_q + periods[35:0];
          ovf_slot_d.bytes_total     = byte_cnt_q + BytesPerRecordSum(2'd1);
        end else begin
          byte_cnt_d = byte_cnt_q + BytesPerRecordSum(2'd1);
        end
        photon_cnt_d = photon_cnt_q + 64'd1;
        fin_slot_d.record_word     = photon_word;
        fin_slot_d.record_valid    = 1'b1;
        fin_slot_d.last_of_item    = 1'b1;
        fin_slot_d.status          = pttre_pkg::StOk;
        fin_slot_d.photons_total   = photon_cnt_q + 64'd1;
        fin_slot_d.overflows_total = ovf_hit ? (ovf_cnt_q + periods[35:0]) : ovf_cnt_q;
        fin_slot_d.bytes_total     = byte_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_macro_q <= 64'd0;
      ovf_cnt_q    <= 36'd0;
      photon_cnt_q <= 64'd0;
      byte_cnt_q   <= 64'd0;
      pend_ovf_q   <= 1'b0;
      pend_fin_q   <= 1'b0;
    end else begin
      last_macro_q <= last_macro_d;
      ovf_cnt_q    <= ovf_cnt_d;
      photon_cnt_q <= photon_cnt_d;
      byte_cnt_q   <= byte_cnt_d;
      pend_ovf_q   <= pend_ovf_d;
      pend_fin_q   <= pend_fin_d;
    end
  end

  // result payload needs no reset, the pending flags guard it
  always_ff @(posedge clk_i) begin
    ovf_slot_q <= ovf_slot_d;
    fin_slot_q <= fin_slot_d;
  end

endmodule

`default_nettype wire
